// ===== rtl/rgb_to_hsv_converter_macros.svh =====
// Assertion macros used by the checker file of the color converter.
// No dependencies; include by bare file name.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Checked on every rising edge of aclk, off while aresetn is low.
`define RHSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define RHSV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/rhsv_pkg.sv =====
// Shared constants and types for the RGB to HSV converter.
// No dependencies.
package rhsv_pkg;

    localparam int COLOR_BITS_DEF    = 8;
    localparam int HUE_FRAC_BITS_DEF = 6;

    // hue sector, picked by the largest component
    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic       undef;   // all components equal
        logic       neg;     // hue difference term is negative
        logic [1:0] sector;
    } rhsv_flags_t;

endpackage

// ===== rtl/rhsv_div_pipe.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; per-stage valid bits and a ready chain let bubbles collapse.
module rhsv_div_pipe #(
    parameter int DEN_W  = 8,
    parameter int Q_W    = 12,
    parameter int SIDE_W = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DEN_W+Q_W-1:0]   in_num_a,
    input  logic [DEN_W-1:0]       in_den_a,
    input  logic [DEN_W+Q_W-1:0]   in_num_b,
    input  logic [DEN_W-1:0]       in_den_b,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [Q_W-1:0]         out_q_a,
    output logic [Q_W-1:0]         out_q_b,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int NUM_W = DEN_W + Q_W;

    logic [Q_W-1:0]    valid_reg;
    logic [Q_W-1:0]    stage_en;
    logic [NUM_W-1:0]  rem_a_reg [Q_W];
    logic [NUM_W-1:0]  rem_b_reg [Q_W];
    logic [DEN_W-1:0]  den_a_reg [Q_W];
    logic [DEN_W-1:0]  den_b_reg [Q_W];
    logic [Q_W-1:0]    q_a_reg   [Q_W];
    logic [Q_W-1:0]    q_b_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;

        logic              v_in;
        logic [NUM_W-1:0]  rem_a_in, rem_b_in;
        logic [DEN_W-1:0]  den_a_in, den_b_in;
        logic [Q_W-1:0]    q_a_in, q_b_in;
        logic [SIDE_W-1:0] side_in;
        logic [NUM_W-1:0]  dsh_a, dsh_b;
        logic              ge_a, ge_b;
        logic [NUM_W-1:0]  rem_a_next, rem_b_next;

        if (k == 0) begin : g_first
            assign v_in     = in_valid;
            assign rem_a_in = in_num_a;
            assign rem_b_in = in_num_b;
            assign den_a_in = in_den_a;
            assign den_b_in = in_den_b;
            assign q_a_in   = '0;
            assign q_b_in   = '0;
            assign side_in  = in_side;
        end else begin : g_next
            assign v_in     = valid_reg[k-1];
            assign rem_a_in = rem_a_reg[k-1];
            assign rem_b_in = rem_b_reg[k-1];
            assign den_a_in = den_a_reg[k-1];
            assign den_b_in = den_b_reg[k-1];
            assign q_a_in   = q_a_reg[k-1];
            assign q_b_in   = q_b_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        if (k == Q_W - 1) begin : g_last_en
            assign stage_en[k] = !valid_reg[k] || out_ready;
        end else begin : g_mid_en
            assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end

        assign dsh_a      = NUM_W'(den_a_in) << SH;
        assign dsh_b      = NUM_W'(den_b_in) << SH;
        assign ge_a       = rem_a_in >= dsh_a;
        assign ge_b       = rem_b_in >= dsh_b;
        assign rem_a_next = ge_a ? rem_a_in - dsh_a : rem_a_in;
        assign rem_b_next = ge_b ? rem_b_in - dsh_b : rem_b_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_en[k]) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[k] && v_in) begin
                rem_a_reg[k] <= rem_a_next;
                rem_b_reg[k] <= rem_b_next;
                den_a_reg[k] <= den_a_in;
                den_b_reg[k] <= den_b_in;
                q_a_reg[k]   <= {q_a_in[Q_W-2:0], ge_a};
                q_b_reg[k]   <= {q_b_in[Q_W-2:0], ge_b};
                side_reg[k]  <= side_in;
            end
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[Q_W-1];
    assign out_q_a   = q_a_reg[Q_W-1];
    assign out_q_b   = q_b_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV converter, one pixel per cycle, fully pipelined.
// Path: stage 1, stage 2, the divider with one quotient bit per stage, then the
// output register; Q_W is the wider quotient (12 bits at defaults).
// Throughput: one pixel per cycle; a stall halts only stages holding data.
// Reset (aresetn low, synchronous) clears all valid bits; no other state.
// Depends on rhsv_pkg and rhsv_div_pipe.
module rgb_to_hsv_converter
    import rhsv_pkg::*;
#(
    parameter int COLOR_BITS    = COLOR_BITS_DEF,
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    localparam int SIXTY        = 60 << HUE_FRAC_BITS,
    localparam int FULL_TURN    = 360 << HUE_FRAC_BITS,
    localparam int HUE_W        = $clog2(FULL_TURN),
    localparam int IN_TDATA_W   = ((3 * COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((HUE_W + 2 * COLOR_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // red, green, blue
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // hue, saturation, brightness
    output logic [0:0]             m_tuser    // hue_undefined
);

    localparam int CB     = COLOR_BITS;
    localparam int HQ_W   = $clog2(SIXTY + 1);
    localparam int Q_W    = (HQ_W > CB) ? HQ_W : CB;
    localparam int NUM_W  = CB + Q_W;
    localparam int FLAG_W = $bits(rhsv_flags_t);
    localparam int SIDE_W = CB + FLAG_W;

    localparam logic [HUE_W-1:0] SIXTY_H = HUE_W'(SIXTY);
    localparam logic [HUE_W:0]   TURN_H  = (HUE_W + 1)'(FULL_TURN);

    // stage 1: max, min, sector and difference operands
    logic [CB-1:0] red, green, blue;
    logic [CB-1:0] hi_next, lo_next, pa_next, pb_next;
    logic [1:0]    sector_next;

    logic          s1_valid_reg;
    logic          s1_en;
    logic [CB-1:0] s1_hi_reg, s1_lo_reg, s1_pa_reg, s1_pb_reg;
    logic [1:0]    s1_sector_reg;

    assign red   = s_tdata[CB-1:0];
    assign green = s_tdata[2*CB-1:CB];
    assign blue  = s_tdata[3*CB-1:2*CB];

    always_comb begin
        if (red >= green && red >= blue) begin
            sector_next = SECTOR_RED;
            hi_next     = red;
            pa_next     = green;
            pb_next     = blue;
        end else if (green >= blue) begin
            sector_next = SECTOR_GREEN;
            hi_next     = green;
            pa_next     = blue;
            pb_next     = red;
        end else begin
            sector_next = SECTOR_BLUE;
            hi_next     = blue;
            pa_next     = red;
            pb_next     = green;
        end
        lo_next = red;
        if (green < lo_next) lo_next = green;
        if (blue < lo_next)  lo_next = blue;
    end

    // stage 2: delta, numerators, flags
    logic              s2_valid_reg;
    logic              s2_en;
    logic              div_in_ready;
    logic [CB-1:0]     delta_next, absdiff_next;
    rhsv_flags_t       flags_next;
    logic [NUM_W-1:0]  num_sat_next, num_hue_next;
    logic [NUM_W-1:0]  s2_num_sat_reg, s2_num_hue_reg;
    logic [CB-1:0]     s2_hi_reg, s2_delta_reg;
    rhsv_flags_t       s2_flags_reg;

    assign s2_en    = !s2_valid_reg || div_in_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en && s_tvalid) begin
            s1_hi_reg     <= hi_next;
            s1_lo_reg     <= lo_next;
            s1_pa_reg     <= pa_next;
            s1_pb_reg     <= pb_next;
            s1_sector_reg <= sector_next;
        end
    end

    always_comb begin
        delta_next        = s1_hi_reg - s1_lo_reg;
        flags_next.undef  = (delta_next == '0);
        flags_next.neg    = (s1_pb_reg > s1_pa_reg);
        flags_next.sector = s1_sector_reg;
        absdiff_next      = flags_next.neg ? s1_pb_reg - s1_pa_reg : s1_pa_reg - s1_pb_reg;
        // delta * (2^CB - 1) as shift and subtract
        num_sat_next      = (NUM_W'(delta_next) << CB) - NUM_W'(delta_next);
        num_hue_next      = NUM_W'(absdiff_next) * NUM_W'(SIXTY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en && s1_valid_reg) begin
            s2_num_sat_reg <= num_sat_next;
            s2_num_hue_reg <= num_hue_next;
            s2_hi_reg      <= s1_hi_reg;
            s2_delta_reg   <= delta_next;
            s2_flags_reg   <= flags_next;
        end
    end

    // divider stages: lane a saturation, lane b hue fraction
    logic              div_out_valid;
    logic              out_en;
    logic [Q_W-1:0]    q_sat, q_hue;
    logic [SIDE_W-1:0] div_side;
    rhsv_flags_t       d_flags;
    logic [CB-1:0]     d_hi;

    rhsv_div_pipe #(
        .DEN_W  (CB),
        .Q_W    (Q_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_ready  (div_in_ready),
        .in_num_a  (s2_num_sat_reg),
        .in_den_a  (s2_hi_reg),
        .in_num_b  (s2_num_hue_reg),
        .in_den_b  (s2_delta_reg),
        .in_side   ({s2_hi_reg, s2_flags_reg}),
        .out_valid (div_out_valid),
        .out_ready (out_en),
        .out_q_a   (q_sat),
        .out_q_b   (q_hue),
        .out_side  (div_side)
    );

    assign d_flags = div_side[FLAG_W-1:0];
    assign d_hi    = div_side[SIDE_W-1:FLAG_W];

    // output stage: sector offset, sign, wrap
    logic [HUE_W-1:0] base_h, q_h, hue_next;
    logic [HUE_W:0]   wrap_h;
    logic             m_valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [CB-1:0]    sat_reg, bri_reg;
    logic             undef_reg;

    assign q_h    = HUE_W'(q_hue);
    assign wrap_h = TURN_H + (HUE_W + 1)'(base_h) - (HUE_W + 1)'(q_h);

    always_comb begin
        case (d_flags.sector)
            SECTOR_GREEN: base_h = HUE_W'(SIXTY_H << 1);
            SECTOR_BLUE:  base_h = HUE_W'(SIXTY_H << 2);
            default:      base_h = '0;
        endcase
        if (d_flags.undef) begin
            hue_next = '0;
        end else if (!d_flags.neg) begin
            hue_next = base_h + q_h;
        end else if (q_h > base_h) begin
            hue_next = wrap_h[HUE_W-1:0];
        end else begin
            hue_next = base_h - q_h;
        end
    end

    assign out_en = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && div_out_valid) begin
            hue_reg   <= hue_next;
            sat_reg   <= d_flags.undef ? '0 : q_sat[CB-1:0];
            bri_reg   <= d_hi;
            undef_reg <= d_flags.undef;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({bri_reg, sat_reg, hue_reg});
    assign m_tuser  = undef_reg;

endmodule

// ===== rtl/rhsv_checker.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhsv_pkg and rgb_to_hsv_converter_macros.svh.
`include "rgb_to_hsv_converter_macros.svh"

module rhsv_checker
    import rhsv_pkg::*;
#(
    parameter int COLOR_BITS    = COLOR_BITS_DEF,
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    localparam int FULL_TURN    = 360 << HUE_FRAC_BITS,
    localparam int HUE_W        = $clog2(FULL_TURN),
    localparam int OUT_TDATA_W  = ((HUE_W + 2 * COLOR_BITS + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0]             m_tuser
);

    localparam logic [HUE_W-1:0] TURN_LAST = HUE_W'(FULL_TURN - 1);

    logic [HUE_W-1:0]      hue;
    logic [COLOR_BITS-1:0] sat;

    assign hue = m_tdata[HUE_W-1:0];
    assign sat = m_tdata[HUE_W+COLOR_BITS-1:HUE_W];

    `RHSV_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid right after reset")
    `RHSV_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `RHSV_ASSERT(a_undef_zero, m_tvalid && m_tuser[0] |-> hue == '0 && sat == '0, "undefined hue with nonzero hue or saturation")
    `RHSV_ASSERT(a_defined_range, m_tvalid && !m_tuser[0] |-> sat != '0 && hue <= TURN_LAST, "defined hue out of range or zero saturation")

endmodule

bind rgb_to_hsv_converter rhsv_checker #(
    .COLOR_BITS    (COLOR_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
) u_rhsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/rgb_to_hsv_converter_tb.sv =====
// Self-checking testbench for rgb_to_hsv_converter: directed table, then random pixels.
// Expected hue/saturation/value are typed into the table or else come from an in-bench fixed-point predictor.
// Depends on rhsv_pkg and the converter RTL.
`timescale 1ns / 100ps

module rgb_to_hsv_converter_tb;
    import rhsv_pkg::*;

    localparam int COLOR_W     = COLOR_BITS_DEF;
    localparam int HUE_SIXTY   = 60 << HUE_FRAC_BITS_DEF;
    localparam int HUE_TURN    = 360 << HUE_FRAC_BITS_DEF;
    localparam int HUE_BITS    = 15;
    localparam int SAT_LSB     = HUE_BITS;
    localparam int VAL_LSB     = HUE_BITS + COLOR_W;
    localparam int IDLE_PCT    = 29;
    localparam int RANDOM_PIX  = 400;
    localparam int DRAIN_WAIT  = 40;       // pipeline is 15 deep at defaults
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic        hue_undefined;
    } hsv_t;

    typedef struct packed {
        pixel_t px;
        logic   known;    // expected value typed in below
        hsv_t   want;
    } color_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // red, green, blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;    // hue, saturation, brightness
    logic [0:0]  m_tuser;    // hue_undefined

    hsv_t hsv_pending_q[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   quiet_stretch = 1'b0;

    color_row_t color_table [] = '{
        '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{15'd0,     8'd0,   8'd0,   1'b1}},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd0,     8'd0,   8'd255, 1'b1}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{15'd0,     8'd0,   8'd128, 1'b1}},
        '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{15'd0,     8'd0,   8'd1,   1'b1}},
        '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{15'd0,     8'd255, 8'd255, 1'b0}},
        '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{15'd7680,  8'd255, 8'd255, 1'b0}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{15'd15360, 8'd255, 8'd255, 1'b0}},
        '{'{8'd255, 8'd255, 8'd0  }, 1'b0, '0},   // red/green tie
        '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},   // green/blue tie
        '{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},   // red/blue tie, hue wraps
        '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '0},   // just below full turn
        '{'{8'd1,   8'd0,   8'd0  }, 1'b0, '0},
        '{'{8'd0,   8'd1,   8'd0  }, 1'b0, '0},
        '{'{8'd0,   8'd0,   8'd1  }, 1'b0, '0},
        '{'{8'd255, 8'd254, 8'd254}, 1'b0, '0},   // smallest delta at full value
        '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
        '{'{8'hAA,  8'h55,  8'hAA }, 1'b0, '0},
        '{'{8'h55,  8'hAA,  8'h55 }, 1'b0, '0},
        '{'{8'd255, 8'd128, 8'd0  }, 1'b0, '0},
        '{'{8'd128, 8'd255, 8'd0  }, 1'b0, '0},
        '{'{8'd0,   8'd128, 8'd255}, 1'b0, '0},
        '{'{8'd170, 8'd85,  8'd255}, 1'b0, '0},
        '{'{8'd10,  8'd20,  8'd30 }, 1'b0, '0},
        '{'{8'd200, 8'd100, 8'd150}, 1'b0, '0}
    };

    rgb_to_hsv_converter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic hsv_t hsv_of(pixel_t px);
        int   r, g, b, hi, lo, delta, hue;
        hsv_t res;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        res.brightness = hi[7:0];
        if (delta == 0) begin
            res.hue           = '0;
            res.saturation    = '0;
            res.hue_undefined = 1'b1;
            return res;
        end
        res.saturation = 8'((delta * 255) / hi);
        // int division truncates toward zero, as the hue term needs
        if (r == hi)
            hue = (HUE_SIXTY * (g - b)) / delta;
        else if (g == hi)
            hue = 2 * HUE_SIXTY + (HUE_SIXTY * (b - r)) / delta;
        else
            hue = 4 * HUE_SIXTY + (HUE_SIXTY * (r - g)) / delta;
        if (hue < 0)
            hue += HUE_TURN;
        res.hue           = 15'(hue);
        res.hue_undefined = 1'b0;
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(pixel_t px, hsv_t want);
        while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {px.blue, px.green, px.red};
        do @(posedge aclk); while (!s_tready);
        hsv_pending_q.push_back(want);
        @(negedge aclk);
    endtask

    function automatic pixel_t random_pixel();
        logic [7:0] a, c;
        pixel_t     px;
        a = 8'($urandom);
        c = 8'($urandom);
        px = 24'($urandom);
        case ($urandom_range(9))
            0: px = '{a, a, a};                 // gray
            1: px = '{a, a, c};
            2: px = '{a, c, a};
            3: px = '{c, a, a};
            default: ;
        endcase
        return px;
    endfunction

    always @(negedge aclk)
        m_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge aclk) begin : result_check
        hsv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (hsv_pending_q.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = hsv_pending_q.pop_front();
                if (m_tdata[HUE_BITS-1:0] !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, m_tdata[HUE_BITS-1:0]);
                    error_count++;
                end
                if (m_tdata[SAT_LSB +: COLOR_W] !== want.saturation) begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, m_tdata[SAT_LSB +: COLOR_W]);
                    error_count++;
                end
                if (m_tdata[VAL_LSB +: COLOR_W] !== want.brightness) begin
                    $error("brightness: expected %0d, got %0d",
                           want.brightness, m_tdata[VAL_LSB +: COLOR_W]);
                    error_count++;
                end
                if (m_tuser[0] !== want.hue_undefined) begin
                    $error("hue_undefined: expected %0b, got %0b",
                           want.hue_undefined, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        pixel_t px;
        hsv_t   want;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (color_table[i]) begin
            want = color_table[i].known ? color_table[i].want : hsv_of(color_table[i].px);
            send_pixel(color_table[i].px, want);
        end

        // hold the input until the pipeline has fully drained
        s_tvalid <= 1'b0;
        while (hsv_pending_q.size() != 0) @(negedge aclk);

        for (int n = 0; n < RANDOM_PIX; n++) begin
            quiet_stretch = (n >= 150 && n < 250);
            px = random_pixel();
            send_pixel(px, hsv_of(px));
        end
        quiet_stretch = 1'b0;
        s_tvalid <= 1'b0;

        while (hsv_pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
